// ===== src/scv_pkg.sv =====
// Shared types and constants for the series cell voltage monitor.
`default_nettype none
package scv_pkg;

    localparam int READING_W = 10;
    localparam int GAIN_W    = 20;
    localparam int MV_W      = 16;
    localparam int COUNT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_TAPS  = 3;
    localparam int Q_FRAC    = 16;

    localparam logic [MV_W-1:0]   MV_MAX         = 16'hFFFF;
    localparam logic [GAIN_W-1:0] TAP1_GAIN_RST  = 20'd376530;
    localparam logic [GAIN_W-1:0] TAP2_GAIN_RST  = 20'd350188;
    localparam logic [GAIN_W-1:0] TAP3_GAIN_RST  = 20'd355006;
    localparam logic [MV_W-1:0]   THRESHOLD_RST  = 16'd3000;

    localparam logic [COUNT_W-1:0] COUNT_NONE  = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_ONE   = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_TWO   = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_THREE = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP1_GAIN = 2'd0,
        REG_TAP2_GAIN = 2'd1,
        REG_TAP3_GAIN = 2'd2,
        REG_THRESHOLD = 2'd3
    } cfg_reg_t;

    // per-lane pipeline control
    typedef struct packed {
        logic acc_en;      // item accepted, add reading
        logic round_end;   // this item closes the round
        logic scale_load;  // snapshot moves into the scaling stage
    } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== src/scv_lane.sv =====
// One tap lane: accumulator, round snapshot and Q16 gain scaling.
`default_nettype none
module scv_lane #(
    parameter int SUM_W = 14,
    parameter int RB    = 10
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  scv_pkg::lane_ctrl_t          ctrl,
    input  wire [scv_pkg::READING_W-1:0] reading,
    input  wire [scv_pkg::GAIN_W-1:0]    gain,
    output logic [SUM_W+scv_pkg::GAIN_W-scv_pkg::Q_FRAC-1:0] scaled
);
    import scv_pkg::*;

    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int V_W    = PROD_W - Q_FRAC;

    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [SUM_W-1:0]  snap_reg, snap_next;
    logic [SUM_W-1:0]  sum_in;
    logic [PROD_W-1:0] prod;
    logic [V_W-1:0]    scaled_reg, scaled_next;

    // reading trimmed to the converter width
    assign sum_in = acc_reg + SUM_W'(reading[RB-1:0]);

    always_comb begin
        acc_next  = acc_reg;
        snap_next = snap_reg;
        if (ctrl.acc_en) begin
            if (ctrl.round_end) begin
                snap_next = sum_in;
                acc_next  = '0;
            end else begin
                acc_next  = sum_in;
            end
        end
    end

    assign prod        = PROD_W'(snap_reg) * PROD_W'(gain);
    assign scaled_next = ctrl.scale_load ? prod[PROD_W-1:Q_FRAC] : scaled_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg   <= snap_next;
        scaled_reg <= scaled_next;
    end

    assign scaled = scaled_reg;

endmodule
`default_nettype wire

// ===== src/scv_merge.sv =====
// Merge stage: cell differences, presence cascade, saturation, result register.
`default_nettype none
module scv_merge #(
    parameter int V_W = 18
) (
    input  wire                        aclk,
    input  wire                        load,
    input  wire [V_W-1:0]              tap_mv [scv_pkg::NUM_TAPS],
    input  wire [scv_pkg::MV_W-1:0]    threshold,
    output logic [scv_pkg::COUNT_W-1:0] cell_count,
    output logic [scv_pkg::MV_W-1:0]   cell1_mv,
    output logic [scv_pkg::MV_W-1:0]   cell2_mv,
    output logic [scv_pkg::MV_W-1:0]   cell3_mv,
    output logic [scv_pkg::MV_W-1:0]   stack_mv
);
    import scv_pkg::*;

    localparam int DW = ((V_W > MV_W) ? V_W : MV_W) + 2;

    function automatic logic [MV_W-1:0] sat_mv(input logic signed [DW-1:0] val);
        logic signed [DW-1:0] lim;
        lim = $signed({{(DW-MV_W){1'b0}}, MV_MAX});
        if (val > lim) return MV_MAX;
        else           return val[MV_W-1:0];
    endfunction

    logic signed [DW-1:0] v1, v2, v3, c1, c2, c3, thr;
    logic                 p1, p2, p3;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [MV_W-1:0]    c1_reg, c1_next, c2_reg, c2_next, c3_reg, c3_next;
    logic [MV_W-1:0]    stack_reg, stack_next;

    assign v1  = $signed({{(DW-V_W){1'b0}}, tap_mv[0]});
    assign v2  = $signed({{(DW-V_W){1'b0}}, tap_mv[1]});
    assign v3  = $signed({{(DW-V_W){1'b0}}, tap_mv[2]});
    assign thr = $signed({{(DW-MV_W){1'b0}}, threshold});

    assign c1 = v1;
    assign c2 = v2 - v1;
    assign c3 = v3 - v2;

    // present cells are strictly above the threshold, hence positive
    assign p1 = c1 > thr;
    assign p2 = c2 > thr;
    assign p3 = c3 > thr;

    always_comb begin
        count_next = count_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        c3_next    = c3_reg;
        stack_next = stack_reg;
        if (load) begin
            stack_next = sat_mv(v3);
            c1_next    = '0;
            c2_next    = '0;
            c3_next    = '0;
            if (!p1) begin
                count_next = COUNT_NONE;
            end else if (!p2) begin
                count_next = COUNT_ONE;
                c1_next    = sat_mv(c1);
            end else begin
                c1_next = sat_mv(c1);
                c2_next = sat_mv(c2);
                if (p3) begin
                    count_next = COUNT_THREE;
                    c3_next    = sat_mv(c3);
                end else begin
                    count_next = COUNT_TWO;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        c1_reg    <= c1_next;
        c2_reg    <= c2_next;
        c3_reg    <= c3_next;
        stack_reg <= stack_next;
    end

    assign cell_count = count_reg;
    assign cell1_mv   = c1_reg;
    assign cell2_mv   = c2_reg;
    assign cell3_mv   = c3_reg;
    assign stack_mv   = stack_reg;

endmodule
`default_nettype wire

// ===== src/series_cell_voltage_monitor.sv =====
// Top level of the three-cell series stack voltage monitor.
//
// Usage:
//   s_ channel: one item carries three tap readings. Each item sums into three
//   per-tap accumulators; after NUM_SAMPLES items (a round) the sums are frozen, scaled to
//   millivolts and turned into cell voltages and a cell count on the m_ channel.
//   cfg channel: writes gains (index 0..2) and presence threshold (index 3); always
//   ready. Write only while no round is partly gathered and no result is in flight.
//   Throughput: one item per cycle while s_tready is high, set by the accumulate in each lane.
//   Pipeline: the snapshot is taken at the edge accepting the last item of a round,
//   then the gain multiply fills the scaling stage and the merge fills the output register.
//   Stall: while m_tready is low the result holds; the snapshot and scaling stages
//   still fill, and items that do not close a round are always taken. s_tready
//   drops only for a round-closing item with no free snapshot slot.
//   Reset: accumulators and round count cleared, pipeline emptied, registers back
//   to their default gains and 3000 mV threshold.
`default_nettype none
module series_cell_voltage_monitor #(
    parameter int NUM_SAMPLES = 10,
    parameter int ADC_BITS    = 10
) (
    input  wire         aclk,
    input  wire         aresetn,
    // tap1_reading [9:0], tap2_reading [19:10], tap3_reading [29:20], zero [31:30]
    input  wire  [31:0] s_tdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // cell_count [1:0], cell1_mv [17:2], cell2_mv [33:18], cell3_mv [49:34],
    // stack_mv [65:50], zero [71:66]
    output logic [71:0] m_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [scv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [scv_pkg::GAIN_W-1:0]    cfg_data
);
    import scv_pkg::*;

    // effective reading width and accumulator sizing
    localparam int RB    = (ADC_BITS < READING_W) ? ADC_BITS : READING_W;
    localparam int SUM_W = $clog2(NUM_SAMPLES * ((1 << RB) - 1) + 1);
    localparam int V_W   = SUM_W + GAIN_W - Q_FRAC;
    localparam int CW    = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam logic [CW-1:0] LAST_ROUND = CW'(NUM_SAMPLES - 1);

    // configuration registers
    logic [GAIN_W-1:0] gain_reg [NUM_TAPS];
    logic [GAIN_W-1:0] gain_next [NUM_TAPS];
    logic [MV_W-1:0]   thr_reg, thr_next;

    // round counter and pipeline occupancy
    logic [CW-1:0] round_reg, round_next;
    logic          snap_vld_reg, snap_vld_next;
    logic          scl_vld_reg, scl_vld_next;
    logic          out_vld_reg, out_vld_next;

    logic       out_free, scl_free, snap_free, round_last, in_acc;
    lane_ctrl_t lane_ctrl;

    logic [READING_W-1:0] reading [NUM_TAPS];
    logic [V_W-1:0]       tap_mv  [NUM_TAPS];

    logic [COUNT_W-1:0] cell_count;
    logic [MV_W-1:0]    cell1_mv, cell2_mv, cell3_mv, stack_mv;

    assign cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < NUM_TAPS; i++) gain_next[i] = gain_reg[i];
        thr_next = thr_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_TAP1_GAIN: gain_next[0] = cfg_data;
                REG_TAP2_GAIN: gain_next[1] = cfg_data;
                REG_TAP3_GAIN: gain_next[2] = cfg_data;
                REG_THRESHOLD: thr_next     = cfg_data[MV_W-1:0];
                default:       thr_next     = thr_reg;
            endcase
        end
    end

    // stall chain from the output register back to the snapshot stage
    assign out_free   = !out_vld_reg || m_tready;
    assign scl_free   = !scl_vld_reg || out_free;
    assign snap_free  = !snap_vld_reg || scl_free;
    assign round_last = (round_reg == LAST_ROUND);
    assign s_tready   = !round_last || snap_free;
    assign in_acc     = s_tvalid && s_tready;

    assign lane_ctrl.acc_en     = in_acc;
    assign lane_ctrl.round_end  = round_last;
    assign lane_ctrl.scale_load = snap_vld_reg && scl_free;

    always_comb begin
        round_next = round_reg;
        if (in_acc) round_next = round_last ? '0 : round_reg + 1'b1;
    end

    always_comb begin
        snap_vld_next = snap_vld_reg;
        if (lane_ctrl.scale_load)     snap_vld_next = 1'b0;
        if (in_acc && round_last)     snap_vld_next = 1'b1;
        scl_vld_next = scl_vld_reg;
        if (scl_vld_reg && out_free)  scl_vld_next = 1'b0;
        if (lane_ctrl.scale_load)     scl_vld_next = 1'b1;
        out_vld_next = out_vld_reg;
        if (out_vld_reg && m_tready)  out_vld_next = 1'b0;
        if (scl_vld_reg && out_free)  out_vld_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg[0]  <= TAP1_GAIN_RST;
            gain_reg[1]  <= TAP2_GAIN_RST;
            gain_reg[2]  <= TAP3_GAIN_RST;
            thr_reg      <= THRESHOLD_RST;
            round_reg    <= '0;
            snap_vld_reg <= 1'b0;
            scl_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_TAPS; i++) gain_reg[i] <= gain_next[i];
            thr_reg      <= thr_next;
            round_reg    <= round_next;
            snap_vld_reg <= snap_vld_next;
            scl_vld_reg  <= scl_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    assign reading[0] = s_tdata[9:0];
    assign reading[1] = s_tdata[19:10];
    assign reading[2] = s_tdata[29:20];

    for (genvar g = 0; g < NUM_TAPS; g++) begin : g_lane
        scv_lane #(
            .SUM_W (SUM_W),
            .RB    (RB)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .reading (reading[g]),
            .gain    (gain_reg[g]),
            .scaled  (tap_mv[g])
        );
    end

    scv_merge #(
        .V_W (V_W)
    ) u_merge (
        .aclk       (aclk),
        .load       (scl_vld_reg && out_free),
        .tap_mv     (tap_mv),
        .threshold  (thr_reg),
        .cell_count (cell_count),
        .cell1_mv   (cell1_mv),
        .cell2_mv   (cell2_mv),
        .cell3_mv   (cell3_mv),
        .stack_mv   (stack_mv)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, stack_mv, cell3_mv, cell2_mv, cell1_mv, cell_count};

    // round counter stays inside the round
    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= LAST_ROUND)
        else $error("round counter past last round");

    // a round-closing item always lands in the snapshot stage
    a_snap_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && round_last) |=> snap_vld_reg)
        else $error("closed round lost");

    // a blocked snapshot is kept
    a_snap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_vld_reg && !scl_free && !(in_acc && round_last)) |=> snap_vld_reg)
        else $error("snapshot dropped while stalled");

    // a new result only follows a filled scaling stage
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(scl_vld_reg))
        else $error("result without scaled data");

    // no cells counted means all cell voltages read zero
    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cell_count == COUNT_NONE) |->
        (cell1_mv == '0 && cell2_mv == '0 && cell3_mv == '0))
        else $error("absent cell with nonzero voltage");

endmodule
`default_nettype wire
